// ----- hdl/mdct_pkg.sv -----
// ----------------------------------------------------------------------------
// mdct_pkg
// Shared constants, types and the quarter-wave cosine table of the MDCT block.
// ----------------------------------------------------------------------------
package mdct_pkg;

  localparam int FRAME_LEN  = 128;
  localparam int COEF_BITS  = 16;
  localparam int HALF_LEN   = FRAME_LEN / 2;

  localparam int SAMPLE_W   = 16;
  localparam int COEF_OUT_W = 23;
  localparam int BIN_OUT_W  = 6;
  localparam int ACC_W      = 40;
  localparam int PROD_W     = SAMPLE_W + COEF_BITS;

  localparam int IDX_W      = $clog2(FRAME_LEN);
  localparam int BIN_W      = $clog2(HALF_LEN);
  localparam int ROM_AW     = $clog2(FRAME_LEN + 1);
  localparam int SCALE_SH   = 31 - COEF_BITS;

  localparam longint          Q30_ONE     = 64'sd1073741824;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  localparam logic signed [ACC_W-1:0] OUT_MAX =
    ACC_W'((longint'(1) <<< (COEF_OUT_W - 1)) - 1);
  localparam logic signed [ACC_W-1:0] OUT_MIN =
    ACC_W'(-(longint'(1) <<< (COEF_OUT_W - 1)));

  // table position modulo 4*FRAME_LEN, kept as quadrant and offset
  typedef struct packed {
    logic [1:0]       q;
    logic [IDX_W-1:0] r;
  } phase_t;

  localparam phase_t PH_START0    = '{q: 2'd0, r: IDX_W'(HALF_LEN + 1)};
  localparam phase_t PH_START_INC = '{q: 2'd1, r: IDX_W'(2)};
  localparam phase_t PH_STEP0     = '{q: 2'd0, r: IDX_W'(2)};
  localparam phase_t PH_STEP_INC  = '{q: 2'd0, r: IDX_W'(4)};

  typedef struct packed {
    logic             wr_en;
    logic             issue;
    logic [IDX_W-1:0] addr;
    logic             bin_init;
    logic             mac_start;
    logic             bin_next;
    logic             out_load;
    logic [BIN_W-1:0] bin;
    logic             last;
  } dp_cmd_t;

  typedef struct packed {
    logic pipe_busy;
    logic out_free;
  } dp_sts_t;

  typedef logic signed [COEF_BITS-1:0] cos_val_t;
  typedef cos_val_t cos_rom_t [FRAME_LEN + 1];

  function automatic phase_t ph_add(phase_t a, phase_t b);
    logic [IDX_W:0] sum;
    logic           carry;
    phase_t         res;
    sum   = {1'b0, a.r} + {1'b0, b.r};
    carry = (sum >= (IDX_W + 1)'(FRAME_LEN));
    res.r = carry ? IDX_W'(sum - (IDX_W + 1)'(FRAME_LEN)) : sum[IDX_W-1:0];
    res.q = a.q + b.q + {1'b0, carry};
    return res;
  endfunction

  function automatic cos_rom_t build_cos_rom();
    cos_rom_t        rom;
    longint unsigned a;
    longint          a2;
    longint          t;
    longint          mag;
    longint          rnd;
    logic            neg;
    for (int m = 0; m <= FRAME_LEN; m++) begin
      if (m == 0) begin
        t = Q30_ONE;
      end else if (m == FRAME_LEN) begin
        t = 0;
      end else begin
        a  = (HALF_PI_Q30 * longint'(unsigned'(m))) / FRAME_LEN;
        a2 = longint'((a * a) >> 30);
        t  = Q30_ONE;
        t  = Q30_ONE - ((a2 * t) / Q30_ONE) / 182;
        t  = Q30_ONE - ((a2 * t) / Q30_ONE) / 132;
        t  = Q30_ONE - ((a2 * t) / Q30_ONE) / 90;
        t  = Q30_ONE - ((a2 * t) / Q30_ONE) / 56;
        t  = Q30_ONE - ((a2 * t) / Q30_ONE) / 30;
        t  = Q30_ONE - ((a2 * t) / Q30_ONE) / 12;
        t  = Q30_ONE - ((a2 * t) / Q30_ONE) / 2;
      end
      neg = (t < 0);
      mag = neg ? -t : t;
      rnd = (mag + (longint'(1) <<< (SCALE_SH - 1))) >>> SCALE_SH;
      if (rnd > (longint'(1) <<< (COEF_BITS - 1)) - 1) begin
        rnd = (longint'(1) <<< (COEF_BITS - 1)) - 1;
      end
      rom[m] = COEF_BITS'(neg ? -rnd : rnd);
    end
    return rom;
  endfunction

  localparam cos_rom_t COS_ROM = build_cos_rom();

endpackage

// ----- hdl/mdct_if.sv -----
// ----------------------------------------------------------------------------
// mdct_if
// Valid/ready channels for samples in and coefficients out.
// ----------------------------------------------------------------------------
interface mdct_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [mdct_pkg::SAMPLE_W-1:0]  sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface mdct_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [mdct_pkg::COEF_OUT_W-1:0] coefficient;
  logic [mdct_pkg::BIN_OUT_W-1:0]         bin_index;
  logic                                   last_bin;

  modport source (output valid, output coefficient, output bin_index, output last_bin,
                  input ready);
  modport sink   (input valid, input coefficient, input bin_index, input last_bin,
                  output ready);
endinterface

// ----- hdl/mdct_ctrl.sv -----
// ----------------------------------------------------------------------------
// mdct_ctrl
// Frame sequencer: fills the buffer, then runs one MAC pass per bin.
// ----------------------------------------------------------------------------
module mdct_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output mdct_pkg::dp_cmd_t cmd,
  input  mdct_pkg::dp_sts_t sts
);
  import mdct_pkg::*;

  localparam logic [1:0] S_FILL  = 2'd0;
  localparam logic [1:0] S_START = 2'd1;
  localparam logic [1:0] S_MAC   = 2'd2;
  localparam logic [1:0] S_WAIT  = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [BIN_W-1:0] bin_r, bin_nxt;
  logic             idx_last;

  assign in_ready = (state_r == S_FILL);
  assign idx_last = (idx_r == IDX_W'(FRAME_LEN - 1));

  always_comb begin
    cmd       = '0;
    cmd.addr  = idx_r;
    cmd.bin   = bin_r;
    cmd.last  = (bin_r == BIN_W'(HALF_LEN - 1));
    state_nxt = state_r;
    idx_nxt   = idx_r;
    bin_nxt   = bin_r;
    unique case (state_r)
      S_FILL: begin
        if (in_valid) begin
          cmd.wr_en = 1'b1;
          if (idx_last) begin
            idx_nxt      = '0;
            bin_nxt      = '0;
            cmd.bin_init = 1'b1;
            state_nxt    = S_START;
          end else begin
            idx_nxt = idx_r + IDX_W'(1);
          end
        end
      end
      S_START: begin
        cmd.mac_start = 1'b1;
        state_nxt     = S_MAC;
      end
      S_MAC: begin
        cmd.issue = 1'b1;
        if (idx_last) begin
          idx_nxt   = '0;
          state_nxt = S_WAIT;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      S_WAIT: begin
        if (!sts.pipe_busy && sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.bin_next = 1'b1;
          if (cmd.last) begin
            state_nxt = S_FILL;
          end else begin
            bin_nxt   = bin_r + BIN_W'(1);
            state_nxt = S_START;
          end
        end
      end
      default: state_nxt = S_FILL;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_FILL;
      idx_r   <= '0;
      bin_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      bin_r   <= bin_nxt;
    end
  end

  a_fill_to_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && idx_last |=> state_r == S_START && bin_r == '0)
    else $error("full frame did not start a MAC pass");

  a_start_issues: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mac_start |=> cmd.issue && idx_r == '0)
    else $error("MAC pass did not begin at sample zero");

  a_last_to_fill: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load && cmd.last |=> state_r == S_FILL && idx_r == '0)
    else $error("final bin did not return to frame fill");

  a_load_drained: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !cmd.issue && !sts.pipe_busy)
    else $error("bin result taken before MAC pipeline drained");

endmodule

// ----- hdl/mdct_datapath.sv -----
// ----------------------------------------------------------------------------
// mdct_datapath
// Frame buffer, cosine phase tracking, one pipelined MAC and the result register.
// ----------------------------------------------------------------------------
module mdct_datapath (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  mdct_pkg::dp_cmd_t                      cmd,
  output mdct_pkg::dp_sts_t                      sts,
  input  logic signed [mdct_pkg::SAMPLE_W-1:0]   in_sample,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [mdct_pkg::COEF_OUT_W-1:0] out_coefficient,
  output logic [mdct_pkg::BIN_OUT_W-1:0]         out_bin_index,
  output logic                                   out_last_bin
);
  import mdct_pkg::*;

  logic signed [SAMPLE_W-1:0]   buf_mem [FRAME_LEN];
  logic signed [SAMPLE_W-1:0]   samp_r;
  phase_t                       start_r, step_r, phase_r;
  logic [ROM_AW-1:0]            rom_addr;
  logic                         cos_neg;
  cos_val_t                     cos_val, cos_r;
  logic signed [PROD_W-1:0]     prod_r;
  logic signed [ACC_W-1:0]      acc_r, acc_sh, coef_sat;
  logic                         v1_r, v2_r, out_valid_r;
  logic signed [COEF_OUT_W-1:0] coef_r;
  logic [BIN_OUT_W-1:0]         bin_r;
  logic                         last_r;

  assign rom_addr = phase_r.q[0] ? ROM_AW'(FRAME_LEN) - ROM_AW'(phase_r.r)
                                 : ROM_AW'(phase_r.r);
  assign cos_neg  = phase_r.q[1] ^ phase_r.q[0];
  assign cos_val  = COS_ROM[rom_addr];

  assign acc_sh   = acc_r >>> (COEF_BITS - 1);
  assign coef_sat = (acc_sh > OUT_MAX) ? OUT_MAX :
                    (acc_sh < OUT_MIN) ? OUT_MIN : acc_sh;

  assign sts.pipe_busy = v1_r | v2_r;
  assign sts.out_free  = !out_valid_r || out_ready;

  assign out_valid       = out_valid_r;
  assign out_coefficient = coef_r;
  assign out_bin_index   = bin_r;
  assign out_last_bin    = last_r;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      buf_mem[cmd.addr] <= in_sample;
    end
    if (cmd.issue) begin
      samp_r <= buf_mem[cmd.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.bin_init) begin
      start_r <= PH_START0;
      step_r  <= PH_STEP0;
    end else if (cmd.bin_next) begin
      start_r <= ph_add(start_r, PH_START_INC);
      step_r  <= ph_add(step_r, PH_STEP_INC);
    end
    if (cmd.mac_start) begin
      phase_r <= start_r;
    end else if (cmd.issue) begin
      phase_r <= ph_add(phase_r, step_r);
    end
    if (cmd.issue) begin
      cos_r <= cos_neg ? -cos_val : cos_val;
    end
    prod_r <= samp_r * cos_r;
    if (cmd.out_load) begin
      coef_r <= coef_sat[COEF_OUT_W-1:0];
      bin_r  <= BIN_OUT_W'(cmd.bin);
      last_r <= cmd.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r <= cmd.issue;
      v2_r <= v1_r;
      if (cmd.mac_start) begin
        acc_r <= '0;
      end else if (v2_r) begin
        acc_r <= acc_r + ACC_W'(prod_r);
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  a_acc_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mac_start |=> acc_r == '0 && !v2_r)
    else $error("accumulator not cleared at start of bin");

  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.issue |-> {1'b0, phase_r.r} < (IDX_W + 1)'(FRAME_LEN))
    else $error("cosine phase offset out of range");

  a_load_visible: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid && out_bin_index == BIN_OUT_W'($past(cmd.bin)))
    else $error("loaded coefficient not presented");

endmodule

// ----- hdl/mdct_frame_transform.sv -----
// ----------------------------------------------------------------------------
// mdct_frame_transform
// MDCT of one frame of Q1.15 samples into FRAME_LEN/2 saturated coefficients.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan  : one signed 16-bit sample per transfer, frame order. Samples are
//              taken only while the frame buffer fills; ready drops during the
//              transform of a full frame.
//   out_chan : FRAME_LEN/2 transfers per frame, bins 0 upward, each with its
//              bin index; last_bin marks the final bin of the frame.
//   Timing   : after the last sample of a frame the bins are computed in
//              order, one multiply-accumulate pass over the frame per bin.
//   Rate     : set by the single multiply-accumulate unit doing one product
//              per cycle during a pass; between bins it waits until the
//              output register is free.
//   Stall    : a coefficient holds in the output register until taken; the
//              next bin is computed meanwhile and waits for the register to
//              free up. Filling of the next frame overlaps the final transfer.
//   Reset    : rst_n (synchronous, active low) empties the frame buffer count
//              and drops out valid; a new frame starts with the next sample.
// ----------------------------------------------------------------------------
module mdct_frame_transform (
  input  logic       clk,
  input  logic       rst_n,
  mdct_in_if.sink    in_chan,
  mdct_out_if.source out_chan
);
  import mdct_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  mdct_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  mdct_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_sample       (in_chan.sample),
    .out_valid       (out_chan.valid),
    .out_ready       (out_chan.ready),
    .out_coefficient (out_chan.coefficient),
    .out_bin_index   (out_chan.bin_index),
    .out_last_bin    (out_chan.last_bin)
  );

endmodule

// ----- tb/mdct_coef_checker.sv -----
// ----------------------------------------------------------------------------
// mdct_coef_checker
// Watches the sample and coefficient channels of the MDCT block. It rebuilds
// each frame from the accepted samples and computes the expected bins from
// its own cosine table and 40-bit accumulator. Each coefficient transfer is
// compared field by field with the oldest expected bin. The failure count
// and the number of bins still due go to the testbench top.
// ----------------------------------------------------------------------------
module mdct_coef_checker (
  input  logic clk,
  input  logic rst_n,
  mdct_in_if   in_mon,
  mdct_out_if  out_mon,
  output int   fail_count,
  output int   bins_pending
);
  import mdct_pkg::*;

  localparam int              TAB_LEN          = 4 * FRAME_LEN;
  localparam int              COS_SHIFT        = 31 - COEF_BITS;
  localparam longint          COS_LIMIT        = (64'sd1 <<< (COEF_BITS - 1)) - 1;
  localparam longint          ONE_Q30          = 64'sd1073741824;
  localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;
  localparam longint          COEF_HI          = (64'sd1 <<< (COEF_OUT_W - 1)) - 1;
  localparam longint          COEF_LO          = -(64'sd1 <<< (COEF_OUT_W - 1));

  typedef struct {
    logic signed [COEF_OUT_W-1:0] coefficient;
    logic [BIN_OUT_W-1:0]         bin_index;
    logic                         last_bin;
  } coef_bin_t;

  int                         cos_tab [TAB_LEN];
  logic signed [SAMPLE_W-1:0] frame_samples [FRAME_LEN];
  int                         fill = 0;
  int                         errs = 0;
  coef_bin_t                  expected_bins [$];

  initial begin
    longint unsigned ang;
    longint          ang_sq;
    longint          t;
    longint          mag;
    longint          rnd;
    int              quad;
    int              m;
    for (int i = 0; i < TAB_LEN; i++) begin
      quad = i / FRAME_LEN;
      m    = (quad == 0 || quad == 2) ? i % FRAME_LEN : FRAME_LEN - i % FRAME_LEN;
      if (m == 0) begin
        t = ONE_Q30;
      end else if (m == FRAME_LEN) begin
        t = 0;
      end else begin
        ang    = (QUARTER_TURN_Q30 * 64'(m)) / 64'(FRAME_LEN);
        ang_sq = longint'((ang * ang) >> 30);
        t      = ONE_Q30;
        for (int j = 7; j >= 1; j--) begin
          t = ONE_Q30 - ((ang_sq * t) / ONE_Q30) / longint'((2 * j - 1) * (2 * j));
        end
      end
      if (quad == 1 || quad == 2) begin
        t = -t;
      end
      mag = (t < 0) ? -t : t;
      rnd = (mag + (64'sd1 <<< (COS_SHIFT - 1))) >>> COS_SHIFT;
      if (rnd > COS_LIMIT) begin
        rnd = COS_LIMIT;
      end
      cos_tab[i] = int'((t < 0) ? -rnd : rnd);
    end
  end

  function automatic coef_bin_t transform_bin(int k);
    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] scaled;
    longint                  lvl;
    int                      idx;
    coef_bin_t               res;
    acc = '0;
    for (int n = 0; n < FRAME_LEN; n++) begin
      idx = ((2 * k + 1) * (2 * n + 1 + HALF_LEN)) % TAB_LEN;
      acc = acc + ACC_W'(longint'(frame_samples[n]) * longint'(cos_tab[idx]));
    end
    scaled = acc >>> (COEF_BITS - 1);
    lvl    = longint'(scaled);
    if (lvl > COEF_HI) begin
      lvl = COEF_HI;
    end else if (lvl < COEF_LO) begin
      lvl = COEF_LO;
    end
    res.coefficient = COEF_OUT_W'(lvl);
    res.bin_index   = BIN_OUT_W'(k);
    res.last_bin    = (k == HALF_LEN - 1);
    return res;
  endfunction

  always @(posedge clk) begin
    coef_bin_t want;
    if (!rst_n) begin
      fill = 0;
      expected_bins.delete();
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        frame_samples[fill] = in_mon.sample;
        fill++;
        if (fill == FRAME_LEN) begin
          fill = 0;
          for (int k = 0; k < HALF_LEN; k++) begin
            expected_bins.insert(expected_bins.size(), transform_bin(k));
          end
        end
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_bins.size() == 0) begin
          errs++;
          $display("%0t: unexpected transfer, coefficient %0d bin %0d last %0b",
                   $time, out_mon.coefficient, out_mon.bin_index, out_mon.last_bin);
        end else begin
          want = expected_bins.pop_front();
          if (out_mon.coefficient !== want.coefficient) begin
            errs++;
            $display("%0t: bin %0d coefficient expected %0d actual %0d", $time,
                     want.bin_index, want.coefficient, out_mon.coefficient);
          end
          if (out_mon.bin_index !== want.bin_index) begin
            errs++;
            $display("%0t: bin_index expected %0d actual %0d", $time,
                     want.bin_index, out_mon.bin_index);
          end
          if (out_mon.last_bin !== want.last_bin) begin
            errs++;
            $display("%0t: bin %0d last_bin expected %0b actual %0b", $time,
                     want.bin_index, want.last_bin, out_mon.last_bin);
          end
        end
      end
    end
    fail_count   <= errs;
    bins_pending <= expected_bins.size();
  end

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Drives frames of samples into the MDCT block and takes its coefficients.
// A corner-value opening is followed by random samples, many of them
// shaped to track one bin's cosine so that the sums grow large. Sender and
// receiver idle at random in two phases and not in a third; the receiver
// holds off once for a long stretch. The checker beside the block predicts
// and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;
  import mdct_pkg::*;

  localparam int SAMPLE_COUNT  = 2 * FRAME_LEN;
  localparam int MODE_B_START  = 160;
  localparam int NO_IDLE_START = 300;
  localparam int HOLD_CYCLES   = 800;
  localparam int QUIET_LIMIT   = 4000;
  localparam int DRAIN_CYCLES  = FRAME_LEN + 8;
  localparam int CORNER_COUNT  = 20;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  int   xfers     = 0;
  int   quiet     = 0;
  int   hold_left = 0;
  logic held      = 1'b0;
  int   fail_count;
  int   bins_pending;
  logic in_xfer;
  logic out_xfer;

  logic signed [SAMPLE_W-1:0] corner_samples [CORNER_COUNT] = '{
    16'sh7FFF, 16'sh8000, 16'sh0000, 16'shFFFF, 16'sh0001,
    16'sh5555, 16'shAAAA, 16'sh4000, 16'shC000, 16'sh00FF,
    16'shFF00, 16'sh0F0F, 16'shF0F0, 16'sh7FFE, 16'sh8001,
    16'sh0100, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF
  };

  mdct_in_if  in_chan();
  mdct_out_if out_chan();

  mdct_frame_transform i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  mdct_coef_checker i_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mon       (in_chan),
    .out_mon      (out_chan),
    .fail_count   (fail_count),
    .bins_pending (bins_pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  assign in_xfer  = in_chan.valid && in_chan.ready;
  assign out_xfer = out_chan.valid && out_chan.ready;

  always @(posedge clk) begin
    xfers <= xfers + int'(in_xfer) + int'(out_xfer);
    if (in_xfer || out_xfer) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // hold off once after the next-to-last bin so the final bin waits
  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left      <= hold_left - 1;
      out_chan.ready <= 1'b0;
    end else if (!held && out_xfer && out_chan.bin_index == BIN_OUT_W'(HALF_LEN - 2)) begin
      held           <= 1'b1;
      hold_left      <= HOLD_CYCLES;
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= ($urandom_range(99) >=
                         ((xfers < MODE_B_START) ? 67 : (xfers < NO_IDLE_START) ? 38 : 0));
    end
  end

  task automatic push_sample(input logic signed [SAMPLE_W-1:0] s);
    while ($urandom_range(99) <
           ((xfers < MODE_B_START) ? 38 : (xfers < NO_IDLE_START) ? 67 : 0)) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid  <= 1'b1;
    in_chan.sample <= s;
    do @(posedge clk); while (!in_chan.ready);
  endtask

  initial begin
    logic signed [SAMPLE_W-1:0] s;
    int                         tgt;
    int                         idx;
    int                         pick;
    int                         mag;
    in_chan.valid  = 1'b0;
    in_chan.sample = '0;
    tgt            = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    for (int i = 0; i < SAMPLE_COUNT; i++) begin
      if (i % FRAME_LEN == 0) begin
        tgt = $urandom_range(HALF_LEN - 1);
      end
      if (i < CORNER_COUNT) begin
        s = corner_samples[i];
      end else begin
        pick = $urandom_range(99);
        if (pick < 35) begin
          s = SAMPLE_W'($urandom);
        end else if (pick < 50) begin
          s = SAMPLE_W'(int'($urandom_range(8)) - 4);
        end else if (pick < 90) begin
          // follow the sign of the target bin's cosine
          idx = ((2 * tgt + 1) * (2 * (i % FRAME_LEN) + 1 + HALF_LEN)) % (4 * FRAME_LEN);
          mag = $urandom_range(32767, 28000);
          s   = (idx / FRAME_LEN == 0 || idx / FRAME_LEN == 3) ? SAMPLE_W'(mag)
                                                               : SAMPLE_W'(-mag);
        end else begin
          s = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
        end
      end
      push_sample(s);
    end
    in_chan.valid <= 1'b0;
    do @(posedge clk); while (bins_pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/mdct_pkg.sv
hdl/mdct_if.sv
hdl/mdct_ctrl.sv
hdl/mdct_datapath.sv
hdl/mdct_frame_transform.sv
tb/mdct_coef_checker.sv
tb/tb.sv
